// ===== rtl/itl_pkg.sv =====
// shared constants, codes and types of the interpolating table lookup
`timescale 1ns / 1ps
package itl_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int NUM_W       = ADDR_W + 1;
    localparam int DATA_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int POS_W       = ADDR_W + FRAC_W;
    localparam int QUO_W       = FRAC_W + 1;
    localparam int PROD_W      = DATA_W + FRAC_W + 2;
    localparam int CNT_W       = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int DIV_CNT_W   = $clog2(QUO_W);

    localparam logic [QUO_W-1:0] Q_ONE  = QUO_W'(1) << FRAC_W;
    localparam logic [POS_W:0]   Q_HALF = (POS_W + 1)'(1) << (FRAC_W - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_MODE  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SNAP_MODE   = CFG_IDX_W'(2);

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SCALE,
        S_ADDR,
        S_MUL,
        S_SUM
    } t_state;

endpackage

// ===== rtl/interpolating_table_lookup.sv =====
// table lookup with clamp or wrap indexing and linear interpolation or snap to the nearest entry
//
//  channel    handshake                      payload
//  command    start / busy                   i_op, i_index_value, i_entry_address,
//                                            i_entry_data
//  result     o_result_strobe (one cycle)    o_result_value
//  config     i_cfg_we                       i_cfg_index, i_cfg_data
//
// a write transaction keeps busy low; a lookup on an empty table gives its result
// the next cycle with busy staying low. any other lookup holds busy through the
// scale, table read, multiply and sum steps (no sum step in snap mode), preceded by the
// serial 1/N divider when clamp mode bounds an index above 1.0.
// reset is synchronous and clears control state; the table itself is not cleared.
// results are shown for one cycle and cannot be stalled.
`timescale 1ns / 1ps
module interpolating_table_lookup (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_op,
    input  logic signed [itl_pkg::DATA_W-1:0] i_index_value,
    input  logic        [7:0]                i_entry_address,
    input  logic signed [itl_pkg::DATA_W-1:0] i_entry_data,
    output logic                             o_result_strobe,
    output logic signed [itl_pkg::DATA_W-1:0] o_result_value,
    input  logic                             i_cfg_we,
    input  logic [itl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [itl_pkg::CNT_W-1:0]        i_cfg_data
);
    import itl_pkg::*;

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_entry_count;
    logic              r_clamp_mode;
    logic              r_snap_mode;

    logic signed [DATA_W-1:0] r_table [TABLE_DEPTH];
    logic signed [DATA_W-1:0] r_rd_a, r_rd_b;

    logic signed [DATA_W-1:0] r_index, n_index;
    logic [NUM_W-1:0]         r_rem, n_rem;
    logic [QUO_W-1:0]         r_quo, n_quo;
    logic [DIV_CNT_W-1:0]     r_div_cnt, n_div_cnt;
    logic [POS_W-1:0]         r_pos, n_pos;
    logic signed [PROD_W-1:0] r_prod_a, n_prod_a;
    logic signed [PROD_W-1:0] r_prod_b, n_prod_b;
    logic                     r_result_strobe, n_result_strobe;
    logic signed [DATA_W-1:0] r_result_value, n_result_value;

    logic                     w_accept;
    logic [NUM_W-1:0]         w_n;
    logic                     w_over;
    logic [NUM_W:0]           w_trial;
    logic [QUO_W-1:0]         w_ux;
    logic [QUO_W-1:0]         w_mul_a;
    logic [NUM_W-1:0]         w_mul_b;
    logic [QUO_W+NUM_W-1:0]   w_scaled;
    logic [ADDR_W-1:0]        w_left, w_right, w_snap, w_addr_a;
    logic [NUM_W-1:0]         w_right_full;
    logic [POS_W:0]           w_round;
    logic [NUM_W-1:0]         w_snap_full;
    logic [FRAC_W-1:0]        w_frac;
    logic [QUO_W-1:0]         w_wt_a;
    logic signed [PROD_W-1:0] w_sum;

    assign w_accept = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);
    assign w_n      = (r_entry_count > CNT_W'(TABLE_DEPTH)) ? NUM_W'(TABLE_DEPTH)
                                                          : r_entry_count[NUM_W-1:0];
    assign w_over   = (i_index_value > $signed({{(DATA_W-QUO_W){1'b0}}, Q_ONE}));

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_clamp_mode  <= 1'b0;
            r_snap_mode   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ENTRY_COUNT: r_entry_count <= i_cfg_data;
                CFG_CLAMP_MODE:  r_clamp_mode  <= i_cfg_data[0];
                CFG_SNAP_MODE:   r_snap_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_op == OP_WRITE) && (int'(i_entry_address) < TABLE_DEPTH)) begin
            r_table[i_entry_address[ADDR_W-1:0]] <= i_entry_data;
        end
        if (r_state == S_ADDR) begin
            r_rd_a <= r_table[w_addr_a];
            r_rd_b <= r_table[w_right];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_op == OP_LOOKUP) && (w_n != '0)) begin
                    n_state = (r_clamp_mode && w_over) ? S_DIV : S_SCALE;
                end
            end
            S_DIV: begin
                if (r_div_cnt == DIV_CNT_W'(QUO_W - 1)) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: n_state = S_ADDR;
            S_ADDR:  n_state = S_MUL;
            S_MUL:   n_state = r_snap_mode ? S_IDLE : S_SUM;
            S_SUM:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        w_trial      = {r_rem, (r_div_cnt == '0)};
        if ($signed(r_index) < 0) begin
            w_ux = '0;
        end else if (r_index > $signed({{(DATA_W-QUO_W){1'b0}}, Q_ONE})) begin
            w_ux = Q_ONE - r_quo;
        end else begin
            w_ux = r_index[QUO_W-1:0];
        end
        w_mul_a      = r_clamp_mode ? w_ux : {1'b0, r_index[FRAC_W-1:0]};
        w_mul_b      = r_clamp_mode ? (w_n - NUM_W'(1)) : w_n;
        w_scaled     = (QUO_W+NUM_W)'(w_mul_a) * (QUO_W+NUM_W)'(w_mul_b);

        w_left       = r_pos[POS_W-1:FRAC_W];
        w_right_full = {1'b0, w_left} + NUM_W'(1);
        w_right      = (w_right_full == w_n) ? '0 : w_right_full[ADDR_W-1:0];
        w_round      = {1'b0, r_pos} + Q_HALF;
        w_snap_full  = w_round[POS_W:FRAC_W];
        w_snap       = (w_snap_full == w_n) ? '0 : w_snap_full[ADDR_W-1:0];
        w_addr_a     = r_snap_mode ? w_snap : w_left;

        w_frac       = r_pos[FRAC_W-1:0];
        w_wt_a       = Q_ONE - {1'b0, w_frac};
        w_sum        = r_prod_a + r_prod_b + PROD_W'(Q_HALF);

        n_index         = r_index;
        n_rem           = r_rem;
        n_quo           = r_quo;
        n_div_cnt       = r_div_cnt;
        n_pos           = r_pos;
        n_prod_a        = r_prod_a;
        n_prod_b        = r_prod_b;
        n_result_strobe = 1'b0;
        n_result_value  = r_result_value;

        unique case (r_state)
            S_IDLE: begin
                n_index   = i_index_value;
                n_rem     = '0;
                n_quo     = '0;
                n_div_cnt = '0;
                if (w_accept && (i_op == OP_LOOKUP) && (w_n == '0)) begin
                    n_result_strobe = 1'b1;
                    n_result_value  = '0;
                end
            end
            S_DIV: begin
                if (w_trial >= {1'b0, w_n}) begin
                    n_rem = NUM_W'(w_trial - {1'b0, w_n});
                    n_quo = {r_quo[QUO_W-2:0], 1'b1};
                end else begin
                    n_rem = w_trial[NUM_W-1:0];
                    n_quo = {r_quo[QUO_W-2:0], 1'b0};
                end
                n_div_cnt = r_div_cnt + DIV_CNT_W'(1);
            end
            S_SCALE: n_pos = w_scaled[POS_W-1:0];
            S_ADDR: ;
            S_MUL: begin
                n_prod_a = PROD_W'($signed({1'b0, w_wt_a})) * PROD_W'(r_rd_a);
                n_prod_b = PROD_W'($signed({2'b00, w_frac})) * PROD_W'(r_rd_b);
                if (r_snap_mode) begin
                    n_result_strobe = 1'b1;
                    n_result_value  = r_rd_a;
                end
            end
            S_SUM: begin
                n_result_strobe = 1'b1;
                n_result_value  = w_sum[FRAC_W+DATA_W-1:FRAC_W];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_result_strobe <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_result_strobe <= n_result_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_index        <= n_index;
        r_rem          <= n_rem;
        r_quo          <= n_quo;
        r_div_cnt      <= n_div_cnt;
        r_pos          <= n_pos;
        r_prod_a       <= n_prod_a;
        r_prod_b       <= n_prod_b;
        r_result_value <= n_result_value;
    end

    assign o_result_strobe = r_result_strobe;
    assign o_result_value  = r_result_value;

endmodule

// ===== rtl/itl_checker.sv =====
// port-level checks for the interpolating table lookup and their binding
`timescale 1ns / 1ps
module itl_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_op,
    input logic o_result_strobe
);
    import itl_pkg::*;

    // a result comes only from a lookup in flight or one just taken
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> ($past(busy) || $past(start && !busy && (i_op == OP_LOOKUP))))
        else $error("result without a pending lookup");

    // a write transaction never yields a result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_op == OP_WRITE)) |=> !o_result_strobe)
        else $error("result after a write transaction");

    // an accepted lookup either answers at once or keeps the block busy
    a_lookup_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_op == OP_LOOKUP)) |=> (busy || o_result_strobe))
        else $error("lookup dropped");

    // leaving busy always delivers the lookup result
    a_busy_ends_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_result_strobe)
        else $error("busy ended without a result");

endmodule

bind interpolating_table_lookup itl_checker u_itl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_op            (i_op),
    .o_result_strobe (o_result_strobe)
);
